>>> hdl/ampp_pkg.sv
// Shared types, constants and the sample quantizer for the min/max peak pyramid.
// No dependencies; used by every other file of the block.
package ampp_pkg;

  localparam int SampleW  = 32;
  localparam int ChanW    = 3;
  localparam int PeakW    = 8;
  localparam int LevelW   = 2;
  localparam int IdxW     = 32;
  localparam int BlenW    = 17;
  localparam int ChansW   = 4;
  localparam int Children = 4;
  localparam int ChildW   = 2;
  localparam int CfgDataW = 17;
  localparam int CfgIdxW  = 1;

  localparam logic [BlenW-1:0]         BlenReset    = 17'd256;
  localparam logic [ChansW-1:0]        ChansReset   = 4'd2;
  localparam logic signed [PeakW-1:0]  PeakMinReset = 8'sd127;
  localparam logic signed [PeakW-1:0]  PeakMaxReset = -8'sd128;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBucketLength = 1'b0,
    CfgChannelCount = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic                    valid;
    logic                    fin;
    logic [ChanW-1:0]        ch;
    logic signed [PeakW-1:0] pmin;
    logic signed [PeakW-1:0] pmax;
  } tok_t;

  typedef struct packed {
    logic [LevelW-1:0]       level;
    logic [ChanW-1:0]        ch;
    logic [IdxW-1:0]         idx;
    logic signed [PeakW-1:0] pmin;
    logic signed [PeakW-1:0] pmax;
  } peak_t;

  typedef struct packed {
    logic  valid;
    logic  fin;
    peak_t peak;
  } cell_res_t;

  typedef struct packed {
    peak_t peak;
    logic  run_end;
  } entry_t;

  // clamp to [-1,1], scale by 127, round half away from zero
  function automatic logic signed [PeakW-1:0] quantize(logic [SampleW-1:0] s);
    logic              neg;
    logic [SampleW-1:0] mag;
    logic [23:0]       clip;
    logic [30:0]       prod;
    logic [PeakW-1:0]  q;
    neg  = s[SampleW-1];
    mag  = neg ? (32'd0 - s) : s;
    clip = (mag > 32'h0080_0000) ? 24'h80_0000 : mag[23:0];
    prod = 31'(clip) * 31'd127 + 31'h0040_0000;
    q    = {1'b0, prod[29:23]};
    return neg ? signed'(8'd0 - q) : signed'(q);
  endfunction

endpackage

>>> hdl/ampp_cell.sv
// One level of the peak pyramid: per-channel running extremes, child count and bucket number.
// Depends on ampp_pkg; instantiated once per level by the top level.
module ampp_cell #(
  parameter int Level       = 0,
  parameter int CntW        = 2,
  parameter int MaxChannels = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [CntW:0]       limit_i,
  input  ampp_pkg::tok_t      tok_i,
  output ampp_pkg::cell_res_t res_o,
  output logic                busy_o
);

  localparam int ChW = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;

  ampp_pkg::tok_t tok;

  generate
    if (Level == 0) begin : g_direct
      assign tok    = tok_i;
      assign busy_o = 1'b0;
    end else begin : g_reg
      ampp_pkg::tok_t tok_q;
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          tok_q <= '0;
        end else begin
          tok_q <= tok_i;
        end
      end
      assign tok    = tok_q;
      assign busy_o = tok_q.valid;
    end
  endgenerate

  logic signed [ampp_pkg::PeakW-1:0] min_q [MaxChannels];
  logic signed [ampp_pkg::PeakW-1:0] max_q [MaxChannels];
  logic [CntW-1:0]                   cnt_q [MaxChannels];
  logic [ampp_pkg::IdxW-1:0]         ctr_q [MaxChannels];

  logic [ChW-1:0]                    sel_ch;
  logic signed [ampp_pkg::PeakW-1:0] new_min, new_max, min_d, max_d;
  logic [CntW:0]                     cnt_inc;
  logic [CntW-1:0]                   cnt_d;
  logic [ampp_pkg::IdxW-1:0]         cur_ctr, ctr_d;
  logic                              close;

  always_comb begin
    sel_ch  = ChW'(tok.ch);
    cur_ctr = ctr_q[sel_ch];
    new_min = (tok.pmin < min_q[sel_ch]) ? tok.pmin : min_q[sel_ch];
    new_max = (tok.pmax > max_q[sel_ch]) ? tok.pmax : max_q[sel_ch];
    cnt_inc = {1'b0, cnt_q[sel_ch]} + {{CntW{1'b0}}, 1'b1};
    close   = tok.fin || (cnt_inc >= limit_i);
    if (close) begin
      min_d = ampp_pkg::PeakMinReset;
      max_d = ampp_pkg::PeakMaxReset;
      cnt_d = '0;
      ctr_d = tok.fin ? '0 : cur_ctr + 32'd1;
    end else begin
      min_d = new_min;
      max_d = new_max;
      cnt_d = cnt_inc[CntW-1:0];
      ctr_d = cur_ctr;
    end
  end

  always_comb begin
    res_o.valid      = tok.valid && close;
    res_o.fin        = tok.fin;
    res_o.peak.level = ampp_pkg::LevelW'(Level);
    res_o.peak.ch    = tok.ch;
    res_o.peak.idx   = cur_ctr;
    res_o.peak.pmin  = new_min;
    res_o.peak.pmax  = new_max;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxChannels; i++) begin
        min_q[i] <= ampp_pkg::PeakMinReset;
        max_q[i] <= ampp_pkg::PeakMaxReset;
        cnt_q[i] <= '0;
        ctr_q[i] <= '0;
      end
    end else if (tok.valid) begin
      min_q[sel_ch] <= min_d;
      max_q[sel_ch] <= max_d;
      cnt_q[sel_ch] <= cnt_d;
      ctr_q[sel_ch] <= ctr_d;
    end
  end

endmodule

>>> hdl/ampp_fifo.sv
// Small result queue in flip-flops, with count and head output.
// Depends on ampp_pkg for the entry type.
module ampp_fifo #(
  parameter int Depth = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  ampp_pkg::entry_t            push_data_i,
  input  logic                        pop_i,
  output logic [$clog2(Depth+1)-1:0]  count_o,
  output ampp_pkg::entry_t            head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  ampp_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  always_comb begin
    wr_d = wr_q;
    rd_d = rd_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + {{(PtrW-1){1'b0}}, 1'b1};
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + {{(PtrW-1){1'b0}}, 1'b1};
    end
    cnt_d = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  assign count_o = cnt_q;
  assign head_o  = mem_q[rd_q];

endmodule

>>> hdl/audio_min_max_peak_pyramid.sv
// Min/max peak pyramid over an interleaved audio stream: quantizes each sample to int8
// and emits per-channel bucket extremes at NUM_LEVELS levels, each four times coarser.
// Depends on ampp_pkg, ampp_cell and ampp_fifo.
//
// Each sample request updates the level-0 cell at once when it is taken, so a stream of
// samples that closes no bucket flows at one request per clock while the result queue has
// room. A request that closes buckets at levels 0 to k passes its bucket down the row of
// level cells, one cell per clock, and holds the input while it walks, through level k+1 if
// there is one; a final-sample request walks all NUM_LEVELS cells and holds the input
// until it has left the last one. Results leave one per clock while out_stall_i is low,
// in level order, from a queue of 2*NUM_LEVELS entries; a new request is taken only
// while at least NUM_LEVELS of those entries are free, so results waiting at the output
// do not block requests until the queue is more than half full. A result passes through
// the hold register and then the queue before it appears on the output.
module audio_min_max_peak_pyramid #(
  parameter int NUM_LEVELS   = 4,
  parameter int MAX_CHANNELS = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [ampp_pkg::SampleW-1:0]   sample_i,
  input  logic [ampp_pkg::ChanW-1:0]            channel_i,
  input  logic                                  final_sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [ampp_pkg::LevelW-1:0]           level_o,
  output logic [ampp_pkg::ChanW-1:0]            out_channel_o,
  output logic [ampp_pkg::IdxW-1:0]             bucket_index_o,
  output logic signed [ampp_pkg::PeakW-1:0]     peak_min_o,
  output logic signed [ampp_pkg::PeakW-1:0]     peak_max_o,
  output logic                                  run_end_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ampp_pkg::CfgIdxW-1:0]          cfg_index_i,
  input  logic [ampp_pkg::CfgDataW-1:0]         cfg_data_i
);

  localparam int FifoDepth = 2 * NUM_LEVELS;
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  // configuration
  logic [ampp_pkg::BlenW-1:0]  blen_q;
  logic [ampp_pkg::ChansW-1:0] chans_q;
  logic [ampp_pkg::BlenW-1:0]  blen_eff;
  logic [ampp_pkg::ChansW-1:0] chans_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blen_q  <= ampp_pkg::BlenReset;
      chans_q <= ampp_pkg::ChansReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (ampp_pkg::cfg_reg_e'(cfg_index_i))
        ampp_pkg::CfgBucketLength: blen_q  <= cfg_data_i[ampp_pkg::BlenW-1:0];
        ampp_pkg::CfgChannelCount: chans_q <= cfg_data_i[ampp_pkg::ChansW-1:0];
        default: ;
      endcase
    end
  end

  assign blen_eff  = (blen_q == '0) ? 17'd1 : blen_q;
  assign chans_eff = (chans_q == '0) ? 4'd1 : chans_q;

  // input request
  logic                              in_acc, ch_ok, pend;
  logic signed [ampp_pkg::PeakW-1:0] q_sample;
  ampp_pkg::tok_t                    fwd [NUM_LEVELS];
  ampp_pkg::cell_res_t               res [NUM_LEVELS];
  logic [NUM_LEVELS-1:0]             busy, emit_vec;

  logic [FifoCntW-1:0] fifo_count;
  logic                hold_valid_q;

  assign pend       = |busy;
  assign in_stall_o = pend ||
                      ((FifoCntW+1)'(fifo_count) + (FifoCntW+1)'(hold_valid_q) >
                       (FifoCntW+1)'(NUM_LEVELS));
  assign in_acc     = in_valid_i && !in_stall_o;
  assign ch_ok      = ({1'b0, channel_i} < chans_eff) &&
                      ({29'd0, channel_i} < 32'(MAX_CHANNELS));
  assign q_sample   = ampp_pkg::quantize(sample_i);

  always_comb begin
    fwd[0].valid = in_acc && ch_ok;
    fwd[0].fin   = final_sample_i;
    fwd[0].ch    = channel_i;
    fwd[0].pmin  = q_sample;
    fwd[0].pmax  = q_sample;
  end

  // row of level cells
  generate
    for (genvar l = 0; l < NUM_LEVELS; l++) begin : g_level
      if (l == 0) begin : g_first
        ampp_cell #(
          .Level       (l),
          .CntW        (ampp_pkg::BlenW),
          .MaxChannels (MAX_CHANNELS)
        ) u_cell (
          .clk_i   (clk_i),
          .rst_ni  (rst_ni),
          .limit_i ({1'b0, blen_eff}),
          .tok_i   (fwd[l]),
          .res_o   (res[l]),
          .busy_o  (busy[l])
        );
      end else begin : g_rest
        always_comb begin
          fwd[l].valid = res[l-1].valid;
          fwd[l].fin   = res[l-1].fin;
          fwd[l].ch    = res[l-1].peak.ch;
          fwd[l].pmin  = res[l-1].peak.pmin;
          fwd[l].pmax  = res[l-1].peak.pmax;
        end
        ampp_cell #(
          .Level       (l),
          .CntW        (ampp_pkg::ChildW),
          .MaxChannels (MAX_CHANNELS)
        ) u_cell (
          .clk_i   (clk_i),
          .rst_ni  (rst_ni),
          .limit_i ((ampp_pkg::ChildW+1)'(ampp_pkg::Children)),
          .tok_i   (fwd[l]),
          .res_o   (res[l]),
          .busy_o  (busy[l])
        );
      end
      assign emit_vec[l] = res[l].valid;
    end
  endgenerate

  // result collection: each result is held in a register to learn whether a coarser one follows
  ampp_pkg::peak_t  sel_peak, hold_q;
  ampp_pkg::entry_t push_data, head;
  logic             any_emit, deep_emit, push, pop;

  always_comb begin
    sel_peak  = '0;
    deep_emit = 1'b0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (res[l].valid) begin
        sel_peak = res[l].peak;
      end
      if (l > 0) begin
        deep_emit = deep_emit || res[l].valid;
      end
    end
  end

  assign any_emit = |emit_vec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= any_emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (any_emit) begin
      hold_q <= sel_peak;
    end
  end

  assign push              = hold_valid_q;
  assign push_data.peak    = hold_q;
  assign push_data.run_end = !deep_emit;

  ampp_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .count_o     (fifo_count),
    .head_o      (head)
  );

  assign out_valid_o    = (fifo_count != '0);
  assign pop            = out_valid_o && !out_stall_i;
  assign level_o        = head.peak.level;
  assign out_channel_o  = head.peak.ch;
  assign bucket_index_o = head.peak.idx;
  assign peak_min_o     = head.peak.pmin;
  assign peak_max_o     = head.peak.pmax;
  assign run_end_o      = head.run_end;

  a_one_cell_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(emit_vec))
    else $error("more than one level cell closed a bucket in the same cycle");

  a_one_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(busy))
    else $error("more than one bucket walking down the cells");

  a_coarse_follows_fine: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deep_emit |-> hold_valid_q)
    else $error("coarse bucket closed without a finer result held");

  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (fifo_count != FifoCntW'(FifoDepth)))
    else $error("result queue overflow");

endmodule
